### hdl/fqf_pkg.sv
// Package for the FASTQ record framer: field tags, error codes, phase codes
// and the result word that travels from the parser to the output stage.
// No dependencies.
package fqf_pkg;

  localparam int unsigned MAX_RECORD_DEFAULT = 65536;

  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;

  typedef enum logic [1:0] {
    TAG_SKIP = 2'd0,
    TAG_HDR  = 2'd1,
    TAG_SEQ  = 2'd2,
    TAG_QUAL = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_PLUS = 2'd1,
    ERR_EOS  = 2'd2,
    ERR_LONG = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_HDR      = 4'd1,
    PH_PRE_SEQ  = 4'd2,
    PH_SEQ      = 4'd3,
    PH_PRE_PLUS = 4'd4,
    PH_PRE_QUAL = 4'd5,
    PH_QUAL     = 4'd6,
    PH_ERR      = 4'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_out;
    tag_t       field_tag;
    logic       record_end;
    err_t       error_code;
  } result_t;

endpackage

### hdl/fqf_if.sv
// Channel interfaces of the FASTQ record framer: the byte input and the
// tagged result output, each with valid/ready. Depends on fqf_pkg.
interface fqf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface fqf_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       byte_out;
  fqf_pkg::tag_t    field_tag;
  logic             record_end;
  fqf_pkg::err_t    error_code;

  modport source (output valid, output byte_out, output field_tag, output record_end,
                  output error_code, input ready);
  modport sink (input valid, input byte_out, input field_tag, input record_end,
                input error_code, output ready);
endinterface

### hdl/fqf_parse.sv
// Parser state machine of the FASTQ record framer: phase, record length and
// sticky error, with the result word of the current byte. Depends on fqf_pkg.
module fqf_parse #(
  parameter int unsigned MAX_RECORD = fqf_pkg::MAX_RECORD_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_stream,
  output fqf_pkg::result_t result
);

  localparam int unsigned LenW = $clog2(MAX_RECORD + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_RECORD);

  fqf_pkg::phase_t phase, phase_next;
  logic [LenW-1:0] record_length, record_length_next;
  fqf_pkg::err_t   error_latch, error_latch_next;

  logic            brk;
  logic [LenW-1:0] len_base;
  logic [LenW-1:0] len_inc;

  always_comb begin
    brk      = (data_byte == fqf_pkg::CHAR_CR) || (data_byte == fqf_pkg::CHAR_LF);
    len_base = (phase == fqf_pkg::PH_IDLE) ? '0 : record_length;
    len_inc  = (len_base <= LenMax) ? len_base + LenW'(1) : len_base;

    phase_next         = phase;
    record_length_next = record_length;
    error_latch_next   = error_latch;
    result.byte_out    = data_byte;
    result.field_tag   = fqf_pkg::TAG_SKIP;
    result.record_end  = 1'b0;

    if (end_of_stream) begin
      result.byte_out = 8'd0;
      if (phase == fqf_pkg::PH_QUAL) begin
        result.record_end  = 1'b1;
        phase_next         = fqf_pkg::PH_IDLE;
        record_length_next = '0;
      end else if (phase != fqf_pkg::PH_IDLE && phase != fqf_pkg::PH_ERR) begin
        error_latch_next = fqf_pkg::ERR_EOS;
        phase_next       = fqf_pkg::PH_ERR;
      end
    end else if (phase == fqf_pkg::PH_ERR) begin
      phase_next = fqf_pkg::PH_ERR;
    end else if (phase == fqf_pkg::PH_IDLE && brk) begin
      phase_next = fqf_pkg::PH_IDLE;
    end else begin
      record_length_next = len_inc;
      if (len_inc > LenMax) begin
        error_latch_next = fqf_pkg::ERR_LONG;
        phase_next       = fqf_pkg::PH_ERR;
      end else begin
        unique case (phase)
          fqf_pkg::PH_IDLE: begin
            result.field_tag = fqf_pkg::TAG_HDR;
            phase_next       = fqf_pkg::PH_HDR;
          end
          fqf_pkg::PH_HDR: begin
            if (brk) phase_next = fqf_pkg::PH_PRE_SEQ;
            else result.field_tag = fqf_pkg::TAG_HDR;
          end
          fqf_pkg::PH_PRE_SEQ: begin
            if (!brk) begin
              result.field_tag = fqf_pkg::TAG_SEQ;
              phase_next       = fqf_pkg::PH_SEQ;
            end
          end
          fqf_pkg::PH_SEQ: begin
            if (brk) phase_next = fqf_pkg::PH_PRE_PLUS;
            else result.field_tag = fqf_pkg::TAG_SEQ;
          end
          fqf_pkg::PH_PRE_PLUS: begin
            if (!brk) begin
              if (data_byte == fqf_pkg::CHAR_PLUS) begin
                phase_next = fqf_pkg::PH_PRE_QUAL;
              end else begin
                error_latch_next = fqf_pkg::ERR_PLUS;
                phase_next       = fqf_pkg::PH_ERR;
              end
            end
          end
          fqf_pkg::PH_PRE_QUAL: begin
            if (!brk) begin
              result.field_tag = fqf_pkg::TAG_QUAL;
              phase_next       = fqf_pkg::PH_QUAL;
            end
          end
          fqf_pkg::PH_QUAL: begin
            if (brk) begin
              result.record_end  = 1'b1;
              phase_next         = fqf_pkg::PH_IDLE;
              record_length_next = '0;
            end else begin
              result.field_tag = fqf_pkg::TAG_QUAL;
            end
          end
          default: begin
            error_latch_next = fqf_pkg::ERR_EOS;
            phase_next       = fqf_pkg::PH_ERR;
          end
        endcase
      end
    end

    result.error_code = error_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= fqf_pkg::PH_IDLE;
      record_length <= '0;
      error_latch   <= fqf_pkg::ERR_NONE;
    end else if (accept) begin
      phase         <= phase_next;
      record_length <= record_length_next;
      error_latch   <= error_latch_next;
    end
  end

  // The error phase and a nonzero latch always go together.
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == fqf_pkg::PH_ERR) == (error_latch != fqf_pkg::ERR_NONE))
    else $error("error phase and error latch disagree");

  // Once set, the error latch holds until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (error_latch != fqf_pkg::ERR_NONE) |=> $stable(error_latch))
    else $error("error latch changed after being set");

  // The length counter saturates one above the record limit.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    record_length <= LenMax + LenW'(1))
    else $error("record length ran past saturation");

endmodule

### hdl/fqf_out_stage.sv
// Output register with a skid entry for the FASTQ record framer, so that a
// byte can be taken while a result waits. Depends on fqf_pkg and fqf_if.
module fqf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  fqf_pkg::result_t  result,
  fqf_out_if.source         dst
);

  logic             out_valid;
  fqf_pkg::result_t out_data;
  logic             skid_valid;
  fqf_pkg::result_t skid_data;
  logic             in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || dst.ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
        if (in_fire) out_data <= result;
      end
    end else if (in_fire) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  assign dst.valid      = out_valid;
  assign dst.byte_out   = out_data.byte_out;
  assign dst.field_tag  = out_data.field_tag;
  assign dst.record_end = out_data.record_end;
  assign dst.error_code = out_data.error_code;

  // The skid entry is only ever filled behind a waiting output word.
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with empty output register");

  // A stalled skid entry is kept.
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !dst.ready) |=> skid_valid)
    else $error("skid entry lost while stalled");

  // When the output word is taken, the skid entry moves forward.
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && dst.ready) |=> (out_valid && !skid_valid))
    else $error("skid entry did not move to the output register");

endmodule

### hdl/fastq_record_framer.sv
// Top level of the FASTQ record framer: tags each byte of a FASTQ stream as
// header, sequence, quality or separator. Depends on fqf_pkg, fqf_if,
// fqf_parse and fqf_out_stage.
//
//   channel     dir  word
//   stream_in   in   data_byte[7:0], end_of_stream
//   record_out  out  byte_out[7:0], field_tag[1:0], record_end, error_code[1:0]
//
// One byte is accepted per cycle while stream_in.ready is high; its result is
// registered in the output stage. The parser state updates in the cycle
// a byte is accepted. Reset is synchronous and clears the phase, the length
// counter and the error latch. A stalled output holds one word plus one skid
// word; stream_in.ready drops only while the skid is full.
module fastq_record_framer #(
  parameter int unsigned MAX_RECORD = fqf_pkg::MAX_RECORD_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  fqf_in_if.sink    stream_in,
  fqf_out_if.source record_out
);

  logic             in_ready;
  logic             accept;
  fqf_pkg::result_t result;

  assign stream_in.ready = in_ready;
  assign accept          = stream_in.valid && in_ready;

  fqf_parse #(
    .MAX_RECORD (MAX_RECORD)
  ) u_parse (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (stream_in.data_byte),
    .end_of_stream (stream_in.end_of_stream),
    .result        (result)
  );

  fqf_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream_in.valid),
    .in_ready (in_ready),
    .result   (result),
    .dst      (record_out)
  );

endmodule

### tb/tb_fastq_record_framer.sv
// Self-checking testbench for fastq_record_framer: drives FASTQ byte words with random
// idling and stalls, predicts every tagged result and compares it field by field.
// Depends on fqf_pkg, fqf_if and the framer RTL.
module tb_fastq_record_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_LIMIT = 256;
  localparam int IDLE_PCT = 35;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;

  fqf_in_if  stream_in ();
  fqf_out_if record_out ();

  fastq_record_framer #(
    .MAX_RECORD(LEN_LIMIT)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .stream_in(stream_in),
    .record_out(record_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fqf_pkg::phase_t parse_phase = fqf_pkg::PH_IDLE;
  int unsigned     rec_len = 0;
  fqf_pkg::err_t   err_latch = fqf_pkg::ERR_NONE;

  fqf_pkg::result_t pending_results[$];
  int send_idle_pct = IDLE_PCT;
  int recv_idle_pct = IDLE_PCT;
  int hold_len = 0;
  int words_sent = 0;
  int words_checked = 0;
  int records_closed = 0;
  int fail_count = 0;
  int cycle_count = 0;
  fqf_pkg::err_t tested_error = fqf_pkg::ERR_NONE;

  function automatic void latch_error(fqf_pkg::err_t code);
    err_latch = code;
    parse_phase = fqf_pkg::PH_ERR;
  endfunction

  function automatic fqf_pkg::result_t frame_byte(logic [7:0] b, logic eos);
    fqf_pkg::result_t r;
    logic brk;
    r.byte_out = b;
    r.field_tag = fqf_pkg::TAG_SKIP;
    r.record_end = 1'b0;
    brk = (b == fqf_pkg::CHAR_CR) || (b == fqf_pkg::CHAR_LF);
    if (eos) begin
      r.byte_out = 8'h00;
      if (parse_phase == fqf_pkg::PH_QUAL) begin
        r.record_end = 1'b1;
        parse_phase = fqf_pkg::PH_IDLE;
        rec_len = 0;
      end else if (parse_phase != fqf_pkg::PH_IDLE && parse_phase != fqf_pkg::PH_ERR) begin
        latch_error(fqf_pkg::ERR_EOS);
      end
    end else if (parse_phase != fqf_pkg::PH_ERR &&
                 !(parse_phase == fqf_pkg::PH_IDLE && brk)) begin
      if (parse_phase == fqf_pkg::PH_IDLE) rec_len = 0;
      if (rec_len <= LEN_LIMIT) rec_len++;
      if (rec_len > LEN_LIMIT) begin
        latch_error(fqf_pkg::ERR_LONG);
      end else begin
        case (parse_phase)
          fqf_pkg::PH_IDLE: begin
            r.field_tag = fqf_pkg::TAG_HDR;
            parse_phase = fqf_pkg::PH_HDR;
          end
          fqf_pkg::PH_HDR: begin
            if (brk) parse_phase = fqf_pkg::PH_PRE_SEQ;
            else r.field_tag = fqf_pkg::TAG_HDR;
          end
          fqf_pkg::PH_PRE_SEQ: begin
            if (!brk) begin
              r.field_tag = fqf_pkg::TAG_SEQ;
              parse_phase = fqf_pkg::PH_SEQ;
            end
          end
          fqf_pkg::PH_SEQ: begin
            if (brk) parse_phase = fqf_pkg::PH_PRE_PLUS;
            else r.field_tag = fqf_pkg::TAG_SEQ;
          end
          fqf_pkg::PH_PRE_PLUS: begin
            if (!brk) begin
              if (b == fqf_pkg::CHAR_PLUS) parse_phase = fqf_pkg::PH_PRE_QUAL;
              else latch_error(fqf_pkg::ERR_PLUS);
            end
          end
          fqf_pkg::PH_PRE_QUAL: begin
            if (!brk) begin
              r.field_tag = fqf_pkg::TAG_QUAL;
              parse_phase = fqf_pkg::PH_QUAL;
            end
          end
          fqf_pkg::PH_QUAL: begin
            if (brk) begin
              r.record_end = 1'b1;
              parse_phase = fqf_pkg::PH_IDLE;
              rec_len = 0;
            end else begin
              r.field_tag = fqf_pkg::TAG_QUAL;
            end
          end
          default: latch_error(fqf_pkg::ERR_EOS);
        endcase
      end
    end
    r.error_code = err_latch;
    return r;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == fqf_pkg::CHAR_CR || b == fqf_pkg::CHAR_LF);
    return b;
  endfunction

  function automatic logic [7:0] break_byte();
    return $urandom_range(1) ? fqf_pkg::CHAR_CR : fqf_pkg::CHAR_LF;
  endfunction

  task automatic send_word(logic [7:0] b, logic eos);
    fqf_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      stream_in.valid <= 1'b0;
      @(posedge clk);
    end
    stream_in.valid <= 1'b1;
    stream_in.data_byte <= b;
    stream_in.end_of_stream <= eos;
    do @(posedge clk); while (!stream_in.ready);
    r = frame_byte(b, eos);
    pending_results.push_back(r);
    words_sent++;
    if (r.record_end) records_closed++;
  endtask

  task automatic send_breaks(int n);
    repeat (n) send_word(break_byte(), 1'b0);
  endtask

  task automatic send_field(int n);
    repeat (n) send_word(text_byte(), 1'b0);
  endtask

  task automatic send_record(int hdr_len, int seq_len, int qual_len, int gap_max,
                             int plus_gap_max, bit close_by_eos);
    send_field(hdr_len);
    send_breaks($urandom_range(gap_max, 1));
    send_field(seq_len);
    send_breaks($urandom_range(gap_max, 1));
    send_word(fqf_pkg::CHAR_PLUS, 1'b0);
    send_breaks($urandom_range(plus_gap_max, 0));
    send_field(qual_len);
    if (close_by_eos) send_word(8'($urandom_range(255)), 1'b1);
    else send_breaks(1);
  endtask

  task automatic send_random_record();
    int span;
    span = ($urandom_range(99) < 5) ? 80 : 40;
    send_record($urandom_range(span, 1), $urandom_range(span, 1), $urandom_range(span, 1),
                3, 2, $urandom_range(99) < 12);
  endtask

  task automatic drain_results();
    stream_in.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // End of stream and breaks while idle, byte extremes, text on the plus line,
  // end of stream during quality, and parsing that continues after it.
  task automatic test_idle_and_extremes();
    send_word(8'hFF, 1'b1);
    send_word(fqf_pkg::CHAR_CR, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(fqf_pkg::CHAR_CR, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(fqf_pkg::CHAR_PLUS, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(fqf_pkg::CHAR_CR, 1'b0);
    send_word(fqf_pkg::CHAR_PLUS, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(fqf_pkg::CHAR_LF, 1'b0);
    send_word(fqf_pkg::CHAR_PLUS, 1'b0);
    send_word(fqf_pkg::CHAR_CR, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'h00, 1'b1);
    send_word(8'h55, 1'b1);
    send_word(8'h40, 1'b0);
    send_record(2, 3, 3, 1, 0, 1'b0);
  endtask

  task automatic test_length_limit();
    send_record(50, 100, 102, 1, 0, 1'b0);
    send_record(1, 1, 1, 1, 0, 1'b0);
  endtask

  task automatic test_random_records(int n);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 80) send_random_record();
      else if (pick < 88) send_breaks($urandom_range(4, 1));
      else if (pick < 94) send_word(8'($urandom_range(255)), 1'b1);
      else send_record(1, 1, 1, 1, 0, $urandom_range(1));
    end
  endtask

  task automatic test_full_rate(int n);
    int start;
    start = words_sent;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (words_sent - start < n) send_random_record();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;
  endtask

  task automatic test_backpressure();
    int start;
    start = words_sent;
    send_idle_pct = 0;
    hold_len = 60;
    while (words_sent - start < 30) send_record($urandom_range(6, 1), $urandom_range(6, 1),
                                                $urandom_range(6, 1), 2, 1, 1'b0);
    send_idle_pct = IDLE_PCT;
    drain_results();
    send_random_record();
  endtask

  // Drives one error into the parser, chosen at random, then checks that the
  // latch holds while more bytes and stream ends pass through.
  task automatic test_sticky_error();
    int stage;
    logic [7:0] b;
    tested_error = fqf_pkg::err_t'($urandom_range(fqf_pkg::ERR_LONG, fqf_pkg::ERR_PLUS));
    case (tested_error)
      fqf_pkg::ERR_PLUS: begin
        send_field($urandom_range(10, 1));
        send_breaks(1);
        send_field($urandom_range(10, 1));
        send_breaks($urandom_range(3, 1));
        do b = text_byte(); while (b == fqf_pkg::CHAR_PLUS);
        send_word(b, 1'b0);
      end
      fqf_pkg::ERR_EOS: begin
        stage = $urandom_range(4);
        send_field($urandom_range(5, 1));
        if (stage >= 1) send_breaks($urandom_range(2, 1));
        if (stage >= 2) send_field($urandom_range(5, 1));
        if (stage >= 3) send_breaks($urandom_range(2, 1));
        if (stage >= 4) send_word(fqf_pkg::CHAR_PLUS, 1'b0);
        send_word(8'($urandom_range(255)), 1'b1);
      end
      default: begin
        send_record(50, 100, 103, 1, 0, 1'b0);
      end
    endcase
    repeat (40) send_word(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  initial begin
    record_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        record_out.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      record_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    fqf_pkg::result_t want;
    if (!rst && record_out.valid && record_out.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: byte_out %0h", record_out.byte_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (record_out.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0h, actual %0h", want.byte_out, record_out.byte_out);
          fail_count++;
        end
        if (record_out.field_tag !== want.field_tag) begin
          $error("field_tag: expected %0d, actual %0d", want.field_tag, record_out.field_tag);
          fail_count++;
        end
        if (record_out.record_end !== want.record_end) begin
          $error("record_end: expected %0d, actual %0d", want.record_end,
                 record_out.record_end);
          fail_count++;
        end
        if (record_out.error_code !== want.error_code) begin
          $error("error_code: expected %0d, actual %0d", want.error_code,
                 record_out.error_code);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fastq_record_framer: mismatch");
      $finish;
    end
  end

  initial begin
    stream_in.valid <= 1'b0;
    stream_in.data_byte <= 8'h00;
    stream_in.end_of_stream <= 1'b0;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_extremes();
    test_length_limit();
    test_random_records(600);
    test_full_rate(200);
    test_backpressure();
    test_sticky_error();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d words and checked %0d results across %0d closed records.",
             words_sent, words_checked, records_closed);
    $display("The run ended with the sticky error case %s latched.", tested_error.name());
    if (fail_count == 0) begin
      $display("fastq_record_framer: match");
    end else begin
      $display("fastq_record_framer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fqf_pkg.sv
hdl/fqf_if.sv
hdl/fqf_parse.sv
hdl/fqf_out_stage.sv
hdl/fastq_record_framer.sv
tb/tb_fastq_record_framer.sv
